// File: src/cds_pkg.sv
// ----------------------------------------------------------------------------
// cds_pkg: calendar date stepper shared types and constants
// Field widths, opcodes, sequencer states and the month length and leap year
// helpers used by the date stepping datapath.
// ----------------------------------------------------------------------------
package cds_pkg;

    localparam int DAY_W   = 5;
    localparam int MON_W   = 4;
    localparam int YEAR_W  = 14;
    localparam int DELTA_W = 20;
    localparam int DIST_W  = 22;
    localparam int KEY_W   = YEAR_W + MON_W + DAY_W;

    localparam logic [YEAR_W-1:0] YEAR_MIN  = YEAR_W'(1);
    localparam logic [YEAR_W-1:0] YEAR_MAX  = YEAR_W'(9999);
    localparam logic [MON_W-1:0]  MON_FIRST = MON_W'(1);
    localparam logic [MON_W-1:0]  MON_LAST  = MON_W'(12);
    localparam logic [MON_W-1:0]  MON_FEB   = MON_W'(2);
    localparam logic [DAY_W-1:0]  DAY_FIRST = DAY_W'(1);
    localparam logic [DAY_W-1:0]  DAY_LAST  = DAY_W'(31);
    localparam logic [DAY_W-1:0]  FEB_LEAP  = DAY_W'(29);

    // reciprocal of 100 scaled by 2^17
    localparam logic [10:0] RECIP_100 = 11'd1311;
    localparam int          RECIP_SH  = 17;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_ADD  = 2'd1,
        OP_DIST = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_CMP,
        ST_STEP,
        ST_FIN
    } t_state;

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [YEAR_W+10:0] prod;
        logic [7:0]         q;
        logic [7:0]         qc;
        logic [YEAR_W:0]    hq;
        logic [YEAR_W:0]    yw;
        logic [YEAR_W:0]    rem;
        prod = (YEAR_W+11)'(y) * (YEAR_W+11)'(RECIP_100);
        q    = prod[RECIP_SH+7:RECIP_SH];
        hq   = ((YEAR_W+1)'(q) << 6) + ((YEAR_W+1)'(q) << 5) + ((YEAR_W+1)'(q) << 2);
        yw   = {1'b0, y};
        if (yw < hq) begin
            qc  = q - 8'd1;
            rem = yw + (YEAR_W+1)'(100) - hq;
        end else begin
            qc  = q;
            rem = yw - hq;
        end
        return (y[1:0] == 2'b00) && ((rem != '0) || (qc[1:0] == 2'b00));
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] d;
        case (m)
            4'd1:    d = 5'd31;
            4'd2:    d = leap ? FEB_LEAP : 5'd28;
            4'd3:    d = 5'd31;
            4'd4:    d = 5'd30;
            4'd5:    d = 5'd31;
            4'd6:    d = 5'd30;
            4'd7:    d = 5'd31;
            4'd8:    d = 5'd31;
            4'd9:    d = 5'd30;
            4'd10:   d = 5'd31;
            4'd11:   d = 5'd30;
            4'd12:   d = 5'd31;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

// File: src/cds_if.sv
// ----------------------------------------------------------------------------
// cds_in_if / cds_out_if: calendar date stepper channels
// Valid/ready channels carrying one request beat and one result beat.
// ----------------------------------------------------------------------------
interface cds_in_if;
    import cds_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [1:0]                opcode;
    logic [DAY_W-1:0]          target_day;
    logic [MON_W-1:0]          target_month;
    logic [YEAR_W-1:0]         target_year;
    logic signed [DELTA_W-1:0] day_delta;

    modport source(output valid, opcode, target_day, target_month, target_year,
                   day_delta, input ready);
    modport sink(input valid, opcode, target_day, target_month, target_year,
                 day_delta, output ready);
endinterface

interface cds_out_if;
    import cds_pkg::*;

    logic               valid;
    logic               ready;
    logic [DAY_W-1:0]   cur_day;
    logic [MON_W-1:0]   cur_month;
    logic [YEAR_W-1:0]  cur_year;
    logic [DIST_W-1:0]  day_distance;
    logic               is_before;
    logic               is_equal;
    logic               range_error;

    modport source(output valid, cur_day, cur_month, cur_year, day_distance,
                   is_before, is_equal, range_error, input ready);
    modport sink(input valid, cur_day, cur_month, cur_year, day_distance,
                 is_before, is_equal, range_error, output ready);
endinterface

// File: src/calendar_date_stepper.sv
// ----------------------------------------------------------------------------
// calendar_date_stepper: Gregorian date register with day stepping
// Loads a date, moves it by a signed day count and measures the distance to
// a target date, one day per cycle through a shared day stepper.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      beat
//  i_in     in   valid/ready    opcode, target date, day_delta
//  o_out    out  valid/ready    stored date, distance, flags
//
//  Load passes the clamp state, add the step state (stopped early at the end
//  of the date range), distance clamp, compare and step; the day stepper
//  moves one day per cycle. i_rst_n is synchronous; the date resets to
//  0001-01-01. One request is in flight at a time; a finished result waits
//  in the output register, and o_out.ready low then holds the sequencer in ST_FIN.
// ----------------------------------------------------------------------------
module calendar_date_stepper (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cds_in_if.sink    i_in,
    cds_out_if.source o_out
);
    import cds_pkg::*;

    t_state            r_state, n_state;
    t_op               r_op, n_op;
    logic              r_dir, n_dir;
    logic [DELTA_W-1:0] r_cnt, n_cnt;
    logic [DAY_W-1:0]  r_wd, n_wd, r_gd, n_gd, r_sd, n_sd;
    logic [MON_W-1:0]  r_wm, n_wm, r_gm, n_gm, r_sm, n_sm;
    logic [YEAR_W-1:0] r_wy, n_wy, r_gy, n_gy, r_sy, n_sy;
    logic [DIST_W-1:0] r_dist, n_dist;
    logic              r_before, n_before, r_equal, n_equal, r_err, n_err;

    logic              r_ovalid, n_ovalid;
    logic [DAY_W-1:0]  r_od, n_od;
    logic [MON_W-1:0]  r_om, n_om;
    logic [YEAR_W-1:0] r_oy, n_oy;
    logic [DIST_W-1:0] r_odist, n_odist;
    logic              r_obef, n_obef, r_oeq, n_oeq, r_oerr, n_oerr;

    logic              in_acc, out_free;
    t_op               in_op;
    logic [MON_W-1:0]  in_mon;
    logic [YEAR_W-1:0] in_year;
    logic [DELTA_W-1:0] in_abs;

    logic              leap, at_max, at_min, edge_hit, step_done;
    logic [DAY_W-1:0]  dim_cur, dim_prev, day_clamped;
    logic [DAY_W-1:0]  sd_day;
    logic [MON_W-1:0]  sd_mon;
    logic [YEAR_W-1:0] sd_year;
    logic [KEY_W-1:0]  key_w, key_g, key_s;

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_acc     = i_in.valid & i_in.ready;
    assign out_free   = ~r_ovalid | o_out.ready;
    assign in_op      = t_op'(i_in.opcode);
    assign in_abs     = i_in.day_delta[DELTA_W-1] ? DELTA_W'(~i_in.day_delta + 1'b1)
                                                  : DELTA_W'(i_in.day_delta);

    always_comb begin
        in_mon = i_in.target_month;
        if (in_mon < MON_FIRST) in_mon = MON_FIRST;
        if (in_mon > MON_LAST) in_mon = MON_LAST;
        in_year = i_in.target_year;
        if (in_year < YEAR_MIN) in_year = YEAR_MIN;
        if (in_year > YEAR_MAX) in_year = YEAR_MAX;
    end

    // shared day stepper on the working date
    assign leap     = is_leap(r_wy);
    assign dim_cur  = month_len(r_wm, leap);
    assign dim_prev = month_len(r_wm - 1'b1, leap);
    assign at_max   = (r_wy == YEAR_MAX) && (r_wm == MON_LAST) && (r_wd == DAY_LAST);
    assign at_min   = (r_wy == YEAR_MIN) && (r_wm == MON_FIRST) && (r_wd == DAY_FIRST);
    assign edge_hit = r_dir ? at_min : at_max;
    assign key_w    = {r_wy, r_wm, r_wd};
    assign key_g    = {r_gy, r_gm, r_gd};
    assign key_s    = {r_sy, r_sm, r_sd};
    assign step_done = (r_op == OP_ADD) ? ((r_cnt == '0) || edge_hit) : (key_w == key_g);

    always_comb begin
        day_clamped = r_wd;
        if (r_wd < DAY_FIRST) day_clamped = DAY_FIRST;
        if (r_wd > dim_cur) day_clamped = dim_cur;
    end

    always_comb begin
        sd_day  = r_wd;
        sd_mon  = r_wm;
        sd_year = r_wy;
        if (!r_dir) begin
            if (r_wd < dim_cur) begin
                sd_day = r_wd + 1'b1;
            end else if (r_wm < MON_LAST) begin
                sd_day = DAY_FIRST;
                sd_mon = r_wm + 1'b1;
            end else begin
                sd_day  = DAY_FIRST;
                sd_mon  = MON_FIRST;
                sd_year = r_wy + 1'b1;
            end
        end else begin
            if (r_wd > DAY_FIRST) begin
                sd_day = r_wd - 1'b1;
            end else if (r_wm > MON_FIRST) begin
                sd_day = dim_prev;
                sd_mon = r_wm - 1'b1;
            end else begin
                sd_day  = DAY_LAST;
                sd_mon  = MON_LAST;
                sd_year = r_wy - 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (in_op)
                        OP_LOAD: n_state = ST_CLAMP;
                        OP_DIST: n_state = ST_CLAMP;
                        OP_ADD:  n_state = ST_STEP;
                        default: n_state = ST_FIN;
                    endcase
                end
            end
            ST_CLAMP: n_state = (r_op == OP_LOAD) ? ST_FIN : ST_CMP;
            ST_CMP:   n_state = ST_STEP;
            ST_STEP: begin
                if (step_done) n_state = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_op = r_op;   n_dir = r_dir;  n_cnt = r_cnt;
        n_wd = r_wd;   n_wm = r_wm;    n_wy = r_wy;
        n_gd = r_gd;   n_gm = r_gm;    n_gy = r_gy;
        n_sd = r_sd;   n_sm = r_sm;    n_sy = r_sy;
        n_dist = r_dist; n_before = r_before; n_equal = r_equal; n_err = r_err;
        n_ovalid = r_ovalid & ~o_out.ready;
        n_od = r_od;   n_om = r_om;    n_oy = r_oy;
        n_odist = r_odist; n_obef = r_obef; n_oeq = r_oeq; n_oerr = r_oerr;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_op     = in_op;
                    n_dir    = i_in.day_delta[DELTA_W-1];
                    n_cnt    = in_abs;
                    n_dist   = '0;
                    n_before = 1'b0;
                    n_equal  = 1'b0;
                    n_err    = 1'b0;
                    if (in_op == OP_ADD) begin
                        n_wd = r_sd;
                        n_wm = r_sm;
                        n_wy = r_sy;
                    end else begin
                        n_wd = i_in.target_day;
                        n_wm = in_mon;
                        n_wy = in_year;
                    end
                end
            end
            ST_CLAMP: begin
                n_wd = day_clamped;
                if (r_op == OP_LOAD) begin
                    n_sd = day_clamped;
                    n_sm = r_wm;
                    n_sy = r_wy;
                end
            end
            ST_CMP: begin
                n_before = (key_s < key_w);
                n_equal  = (key_s == key_w);
                n_dir    = 1'b0;
                if (key_s < key_w) begin
                    n_gd = r_wd; n_gm = r_wm; n_gy = r_wy;
                    n_wd = r_sd; n_wm = r_sm; n_wy = r_sy;
                end else begin
                    n_gd = r_sd; n_gm = r_sm; n_gy = r_sy;
                end
            end
            ST_STEP: begin
                if (!step_done) begin
                    n_wd = sd_day;
                    n_wm = sd_mon;
                    n_wy = sd_year;
                    if (r_op == OP_ADD) n_cnt = r_cnt - 1'b1;
                    else n_dist = r_dist + 1'b1;
                end else if (r_op == OP_ADD) begin
                    n_sd  = r_wd;
                    n_sm  = r_wm;
                    n_sy  = r_wy;
                    n_err = (r_cnt != '0);
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_od     = r_sd;
                    n_om     = r_sm;
                    n_oy     = r_sy;
                    n_odist  = r_dist;
                    n_obef   = r_before;
                    n_oeq    = r_equal;
                    n_oerr   = r_err;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_sd     <= DAY_FIRST;
            r_sm     <= MON_FIRST;
            r_sy     <= YEAR_MIN;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_sd     <= n_sd;
            r_sm     <= n_sm;
            r_sy     <= n_sy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_dir    <= n_dir;
        r_cnt    <= n_cnt;
        r_wd     <= n_wd;
        r_wm     <= n_wm;
        r_wy     <= n_wy;
        r_gd     <= n_gd;
        r_gm     <= n_gm;
        r_gy     <= n_gy;
        r_dist   <= n_dist;
        r_before <= n_before;
        r_equal  <= n_equal;
        r_err    <= n_err;
        r_od     <= n_od;
        r_om     <= n_om;
        r_oy     <= n_oy;
        r_odist  <= n_odist;
        r_obef   <= n_obef;
        r_oeq    <= n_oeq;
        r_oerr   <= n_oerr;
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.cur_day      = r_od;
    assign o_out.cur_month    = r_om;
    assign o_out.cur_year     = r_oy;
    assign o_out.day_distance = r_odist;
    assign o_out.is_before    = r_obef;
    assign o_out.is_equal     = r_oeq;
    assign o_out.range_error  = r_oerr;

    a_stored_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sm >= MON_FIRST) && (r_sm <= MON_LAST) && (r_sd >= DAY_FIRST) &&
        (r_sy >= YEAR_MIN) && (r_sy <= YEAR_MAX))
        else $error("stored date left the valid range");

    a_dist_no_overshoot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STEP) && (r_op == OP_DIST) |-> (key_w <= key_g))
        else $error("distance walk passed its goal date");

    a_add_countdown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STEP) && (r_op == OP_ADD) && !step_done
        |=> (r_cnt == $past(r_cnt) - 1'b1))
        else $error("day counter did not advance with the stepper");

    a_result_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.range_error |-> !o_out.is_equal && !o_out.is_before &&
        (o_out.day_distance == '0))
        else $error("range error mixed with compare results");

endmodule

// File: dv/calendar_date_stepper_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calendar_date_stepper_tb: self-checking bench for the Gregorian date stepper
// Drives load, add, distance and idle opcodes through the request channel,
// predicts every result beat from a day-number calendar model and checks each
// beat field by field, under several mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module calendar_date_stepper_tb;
    import cds_pkg::*;

    localparam int LAST_DAY_NUMBER = 3652058;   // 9999-12-31 counted from 0001-01-01

    typedef struct {
        int day;
        int month;
        int year;
    } t_cal_date;

    typedef struct packed {
        logic [DAY_W-1:0]  day;
        logic [MON_W-1:0]  month;
        logic [YEAR_W-1:0] year;
        logic [DIST_W-1:0] distance;
        logic              precedes;
        logic              equal;
        logic              range_err;
    } t_step_result;

    logic i_clk;
    logic i_rst_n;

    cds_in_if  in_if();
    cds_out_if out_if();

    calendar_date_stepper dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_cal_date    cal_date;
    t_step_result pending_results[$];
    int           send_idle_pct;
    int           recv_stall_pct;
    int           mismatch_count;
    int           beats_checked;
    int           op_count[4];
    int           range_stop_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #100_000_000;
        $display("%0t: timeout, %0d results still pending", $time, pending_results.size());
        $display("Simulation FAILED");
        $finish;
    end

    function automatic bit leap_year(int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int month_days(int m, int y);
        case (m)
            2:           return leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    function automatic int days_before_year(int y);
        int p;
        p = y - 1;
        return 365 * p + p / 4 - p / 100 + p / 400;
    endfunction

    function automatic int day_number(t_cal_date dt);
        int n;
        int k;
        n = days_before_year(dt.year);
        for (k = 1; k < dt.month; k++) n += month_days(k, dt.year);
        return n + dt.day - 1;
    endfunction

    function automatic t_cal_date date_of_day_number(int n);
        t_cal_date dt;
        int        rest;
        dt.year = int'((longint'(n) * 400) / 146097) + 1;
        if (dt.year > 9999) dt.year = 9999;
        while (dt.year < 9999 && days_before_year(dt.year + 1) <= n) dt.year++;
        while (dt.year > 1 && days_before_year(dt.year) > n) dt.year--;
        rest     = n - days_before_year(dt.year);
        dt.month = 1;
        while (dt.month < 12 && rest >= month_days(dt.month, dt.year)) begin
            rest -= month_days(dt.month, dt.year);
            dt.month++;
        end
        dt.day = rest + 1;
        return dt;
    endfunction

    function automatic t_cal_date clamp_target(logic [DAY_W-1:0] d, logic [MON_W-1:0] m,
                                               logic [YEAR_W-1:0] y);
        t_cal_date dt;
        int        lim;
        dt.month = (m < 1) ? 1 : (m > 12) ? 12 : int'(m);
        dt.year  = (y < 1) ? 1 : (y > 9999) ? 9999 : int'(y);
        lim      = month_days(dt.month, dt.year);
        dt.day   = (d < 1) ? 1 : (d > lim) ? lim : int'(d);
        return dt;
    endfunction

    function automatic t_step_result predict_step(t_op op, logic [DAY_W-1:0] d,
                                                  logic [MON_W-1:0] m, logic [YEAR_W-1:0] y,
                                                  logic signed [DELTA_W-1:0] delta);
        t_step_result r;
        t_cal_date    tgt;
        int           a;
        int           b;
        longint       n;
        r = '0;
        case (op)
            OP_LOAD: cal_date = clamp_target(d, m, y);
            OP_ADD: begin
                n = longint'(day_number(cal_date)) + longint'(delta);
                if (n < 0) begin
                    n           = 0;
                    r.range_err = 1'b1;
                end
                if (n > LAST_DAY_NUMBER) begin
                    n           = LAST_DAY_NUMBER;
                    r.range_err = 1'b1;
                end
                cal_date = date_of_day_number(int'(n));
                range_stop_count += r.range_err;
            end
            OP_DIST: begin
                tgt        = clamp_target(d, m, y);
                a          = day_number(cal_date);
                b          = day_number(tgt);
                r.distance = DIST_W'((a < b) ? b - a : a - b);
                r.precedes = (a < b);
                r.equal    = (a == b);
            end
            default: ;
        endcase
        r.day   = DAY_W'(cal_date.day);
        r.month = MON_W'(cal_date.month);
        r.year  = YEAR_W'(cal_date.year);
        return r;
    endfunction

    task automatic send_request(t_op op, logic [DAY_W-1:0] d, logic [MON_W-1:0] m,
                                logic [YEAR_W-1:0] y, logic signed [DELTA_W-1:0] delta);
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.opcode       <= op;
        in_if.target_day   <= d;
        in_if.target_month <= m;
        in_if.target_year  <= y;
        in_if.day_delta    <= delta;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        pending_results.push_back(predict_step(op, d, m, y, delta));
        op_count[op]++;
    endtask

    task automatic load_date(int d, int m, int y);
        send_request(OP_LOAD, DAY_W'(d), MON_W'(m), YEAR_W'(y), '0);
    endtask

    task automatic add_days(int delta);
        send_request(OP_ADD, '0, '0, '0, DELTA_W'(delta));
    endtask

    task automatic measure_to(int d, int m, int y);
        send_request(OP_DIST, DAY_W'(d), MON_W'(m), YEAR_W'(y), '0);
    endtask

    function automatic void check_field(string name, logic [DIST_W-1:0] want,
                                        logic [DIST_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void check_result();
        t_step_result want;
        if (pending_results.size() == 0) begin
            $display("%0t: result beat with nothing pending, date %0d-%0d-%0d", $time,
                     out_if.cur_year, out_if.cur_month, out_if.cur_day);
            mismatch_count++;
            return;
        end
        want = pending_results.pop_front();
        check_field("cur_day", DIST_W'(want.day), DIST_W'(out_if.cur_day));
        check_field("cur_month", DIST_W'(want.month), DIST_W'(out_if.cur_month));
        check_field("cur_year", DIST_W'(want.year), DIST_W'(out_if.cur_year));
        check_field("day_distance", want.distance, out_if.day_distance);
        check_field("is_before", DIST_W'(want.precedes), DIST_W'(out_if.is_before));
        check_field("is_equal", DIST_W'(want.equal), DIST_W'(out_if.is_equal));
        check_field("range_error", DIST_W'(want.range_err), DIST_W'(out_if.range_error));
        beats_checked++;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) check_result();
            out_if.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    task automatic test_reset_state();
        send_request(OP_NONE, '1, '1, '1, '1);
        send_request(OP_NONE, '0, '0, '0, '0);
    endtask

    task automatic test_load_clamping();
        load_date(0, 0, 0);
        load_date(31, 15, 16383);
        load_date(31, 2, 2000);
        load_date(29, 2, 1900);
        load_date(31, 4, 2024);
    endtask

    task automatic test_leap_rules();
        load_date(28, 2, 2000);
        add_days(1);
        add_days(1);
        add_days(-1);
        load_date(1, 3, 1900);
        add_days(-1);
        load_date(1, 3, 2024);
        add_days(-1);
        load_date(31, 12, 1999);
        add_days(1);
    endtask

    task automatic test_range_limits();
        load_date(1, 1, 1);
        add_days(-524288);
        load_date(31, 12, 9999);
        add_days(524287);
        load_date(5, 1, 2);
        add_days(-400);
        add_days(0);
    endtask

    task automatic test_distance_compare();
        load_date(29, 2, 2000);
        measure_to(29, 2, 1600);
        measure_to(29, 2, 2000);
        measure_to(2, 3, 2000);
        measure_to(31, 2, 2000);
        add_days(-146097);
    endtask

    task automatic run_random_phase(int send_pct, int recv_pct, int count);
        t_cal_date tgt;
        int        pick;
        int        n;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count) begin
            pick = $urandom_range(99, 0);
            if (pick < 15) begin
                send_request(OP_LOAD, DAY_W'($urandom), MON_W'($urandom),
                             YEAR_W'($urandom), DELTA_W'($urandom));
            end else if (pick < 50) begin
                send_request(OP_ADD, DAY_W'($urandom), MON_W'($urandom), YEAR_W'($urandom),
                             DELTA_W'($urandom_range(6000, 0) - 3000));
            end else if (pick < 90) begin
                n = day_number(cal_date) + $urandom_range(6000, 0) - 3000;
                if (n < 0) n = 0;
                if (n > LAST_DAY_NUMBER) n = LAST_DAY_NUMBER;
                if ($urandom_range(9, 0) == 0) n = day_number(cal_date);
                tgt = date_of_day_number(n);
                if ($urandom_range(4, 0) == 0) tgt.day = $urandom_range(1, 0) ? 31 : 0;
                if ($urandom_range(9, 0) == 0) tgt.month = $urandom_range(1, 0) ?
                                                           $urandom_range(15, 13) : 0;
                send_request(OP_DIST, DAY_W'(tgt.day), MON_W'(tgt.month),
                             YEAR_W'(tgt.year), DELTA_W'($urandom));
            end else begin
                send_request(OP_NONE, DAY_W'($urandom), MON_W'($urandom),
                             YEAR_W'($urandom), DELTA_W'($urandom));
            end
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0, 25);
        run_random_phase(76, 0, 25);
        run_random_phase(0, 76, 25);
        run_random_phase(22, 22, 25);
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        in_if.valid        <= 1'b0;
        in_if.opcode       <= OP_NONE;
        in_if.target_day   <= '0;
        in_if.target_month <= '0;
        in_if.target_year  <= '0;
        in_if.day_delta    <= '0;
        cal_date           = '{day: 1, month: 1, year: 1};
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_load_clamping();
        test_leap_rules();
        test_range_limits();
        test_distance_compare();
        test_random_traffic();
        in_if.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Checked %0d result beats: %0d loads, %0d adds, %0d distances, %0d idle ops",
                 beats_checked, op_count[OP_LOAD], op_count[OP_ADD], op_count[OP_DIST],
                 op_count[OP_NONE]);
        $display("Adds stopped at a year edge: %0d; mismatches: %0d",
                 range_stop_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
